### hw/rtl/trd_pkg.sv
// Package for the TGA run-length decoder: widths, register map, reset values,
// the pixel item passed from the parser to the accounting stage.
// No dependencies.
`timescale 1ns / 1ps

package trd_pkg;

  localparam int BYTE_W  = 8;
  localparam int PIX_W   = 32;
  localparam int BPP_W   = 3;
  localparam int POS_W   = 2;
  localparam int CNT_W   = 8;
  localparam int TOTAL_W = 25;

  localparam int MAX_BYTES_PER_PIXEL_DEF = 4;

  // Header byte layout
  localparam int HDR_RUN_BIT = 7;
  localparam logic [BYTE_W-2:0] HDR_LEN_MASK = 7'd127;

  // APB register map
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_BPP   = 1'b0;
  localparam logic REG_TOTAL = 1'b1;

  localparam logic [BPP_W-1:0]   BPP_RST   = 3'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_RST = 25'd65536;

  // Queue between parser and accounting stage
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             is_run;
    logic [CNT_W-1:0] count;     // run length for a run packet
    logic             pkt_last;  // last pixel of its packet
  } trd_item_t;

  // Zero pixel total counts as one pixel
  function automatic logic [TOTAL_W-1:0] eff_total(input logic [TOTAL_W-1:0] t);
    eff_total = (t == '0) ? TOTAL_W'(1) : t;
  endfunction

endpackage

### hw/rtl/trd_stream_if.sv
// Valid/ready channel interfaces for the TGA run-length decoder:
// a byte channel in, a pixel channel out. Depends on trd_pkg.
`timescale 1ns / 1ps

interface trd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [trd_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface trd_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [trd_pkg::PIX_W-1:0] pixel_value;
  logic [trd_pkg::CNT_W-1:0] repeat_count;
  logic                      last_of_image;
  logic                      overrun;

  modport source (output valid, output pixel_value, output repeat_count,
                  output last_of_image, output overrun, input ready);
  modport sink   (input valid, input pixel_value, input repeat_count,
                  input last_of_image, input overrun, output ready);
endinterface

### hw/rtl/trd_front.sv
// Parser front end: takes stream bytes, tracks packet headers, gathers pixel
// bytes and pushes one item per completed pixel. Depends on trd_pkg, trd_byte_if.
`timescale 1ns / 1ps

module trd_front #(
  parameter int MAX_BPP = trd_pkg::MAX_BYTES_PER_PIXEL_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  trd_byte_if.sink                    in_ch,
  input  logic [trd_pkg::BPP_W-1:0]   bpp_cfg,
  input  logic                        q_full,
  output logic                        q_push,
  output trd_pkg::trd_item_t          q_item
);
  import trd_pkg::*;

  typedef enum logic {PH_HEADER, PH_PIXEL} phase_t;

  phase_t            phase_r, phase_nxt;
  logic              is_run_r, is_run_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [PIX_W-1:0]  gather_r, gather_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;

  logic [BPP_W-1:0]  bpp_eff;
  logic [PIX_W-1:0]  gather_cur;
  logic              accept;
  logic              done;

  // Clamp pixel size into 1..MAX_BPP
  always_comb begin
    if (bpp_cfg == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_cfg > BPP_W'(MAX_BPP)) begin
      bpp_eff = BPP_W'(MAX_BPP);
    end else begin
      bpp_eff = bpp_cfg;
    end
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Drop the byte into its lane of the gather word
  always_comb begin
    gather_cur = gather_r;
    gather_cur[{pos_r, 3'b000} +: BYTE_W] = in_ch.in_byte;
  end

  assign done = (({1'b0, pos_r} + BPP_W'(1)) >= bpp_eff);

  // Packet sequencing
  always_comb begin
    phase_nxt  = phase_r;
    is_run_nxt = is_run_r;
    pos_nxt    = pos_r;
    gather_nxt = gather_r;
    left_nxt   = left_r;
    q_push     = 1'b0;
    q_item.value    = gather_cur;
    q_item.is_run   = is_run_r;
    q_item.count    = left_r;
    q_item.pkt_last = is_run_r || (left_r == CNT_W'(1));
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          is_run_nxt = in_ch.in_byte[HDR_RUN_BIT];
          left_nxt   = {1'b0, in_ch.in_byte[BYTE_W-2:0] & HDR_LEN_MASK} + CNT_W'(1);
          pos_nxt    = '0;
          gather_nxt = '0;
          phase_nxt  = PH_PIXEL;
        end
        PH_PIXEL: begin
          if (!done) begin
            gather_nxt = gather_cur;
            pos_nxt    = pos_r + POS_W'(1);
          end else begin
            q_push     = 1'b1;
            gather_nxt = '0;
            pos_nxt    = '0;
            if (is_run_r) begin
              left_nxt  = '0;
              phase_nxt = PH_HEADER;
            end else begin
              left_nxt = left_r - CNT_W'(1);
              if (left_r == CNT_W'(1)) begin
                phase_nxt = PH_HEADER;
              end
            end
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      is_run_r <= 1'b0;
      pos_r    <= '0;
      gather_r <= '0;
      left_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      is_run_r <= is_run_nxt;
      pos_r    <= pos_nxt;
      gather_r <= gather_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

### hw/rtl/trd_queue.sv
// Two-entry queue of pixel items between parser and accounting stage.
// Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  trd_pkg::trd_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output trd_pkg::trd_item_t  head
);
  import trd_pkg::*;

  trd_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/trd_back.sv
// Accounting back end: counts pixels against the image size, clips packets
// at the image end, drops the tail of a clipped raw packet and registers the
// result beat. Depends on trd_pkg, trd_pixel_if.
`timescale 1ns / 1ps

module trd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  trd_pkg::trd_item_t            q_head,
  output logic                          q_pop,
  input  logic                          reload,
  input  logic [trd_pkg::TOTAL_W-1:0]   reload_total,
  input  logic [trd_pkg::TOTAL_W-1:0]   total_eff,
  trd_pixel_if.source                   out_ch
);
  import trd_pkg::*;

  logic [TOTAL_W-1:0] image_left_r, image_left_nxt;
  logic               skip_r, skip_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_value_r;
  logic [CNT_W-1:0]   out_rep_r, rep;
  logic               out_last_r, out_ovr_r;
  logic               ovr, last, emit;
  logic               run_clip;
  logic [TOTAL_W-1:0] left_after;
  logic               can_take;

  assign can_take = !out_valid_r || out_ch.ready;
  assign q_pop    = q_valid && can_take;
  assign run_clip = ({{(TOTAL_W-CNT_W){1'b0}}, q_head.count} > image_left_r);

  // Clip against the pixels left in the image
  always_comb begin
    skip_nxt = skip_r;
    emit     = 1'b0;
    ovr      = 1'b0;
    rep      = CNT_W'(1);
    if (q_head.is_run) begin
      rep        = run_clip ? image_left_r[CNT_W-1:0] : q_head.count;
      ovr        = run_clip;
      left_after = run_clip ? '0
                            : image_left_r - {{(TOTAL_W-CNT_W){1'b0}}, q_head.count};
    end else begin
      left_after = image_left_r - TOTAL_W'(1);
      ovr        = (left_after == '0) && !q_head.pkt_last;
    end
    last = (left_after == '0);
    image_left_nxt = image_left_r;
    if (q_pop) begin
      if (skip_r) begin
        if (q_head.pkt_last) begin
          skip_nxt = 1'b0;
        end
      end else begin
        emit           = 1'b1;
        skip_nxt       = ovr && !q_head.is_run;
        image_left_nxt = last ? total_eff : left_after;
      end
    end
    if (reload) begin
      image_left_nxt = reload_total;
    end
    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_left_r <= TOTAL_RST;
      skip_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      image_left_r <= image_left_nxt;
      skip_r       <= skip_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Load result beat
  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= q_head.value;
      out_rep_r   <= rep;
      out_last_r  <= last;
      out_ovr_r   <= ovr;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_value   = out_value_r;
  assign out_ch.repeat_count  = out_rep_r;
  assign out_ch.last_of_image = out_last_r;
  assign out_ch.overrun       = out_ovr_r;

  // A clipped packet always closes the image
  a_ovr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovr_r |-> out_last_r)
    else $error("overrun beat without last_of_image");

  // Remaining image count never reaches zero between pixels
  a_left_nz: assert property (@(posedge clk) disable iff (!rst_n)
    image_left_r != '0)
    else $error("image_left at zero");

  // Skipping starts only with a clipped raw pixel on the output
  a_skip_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skip_r) |-> out_valid_r && out_ovr_r)
    else $error("skip entered without overrun beat");

  // Repeat count of a delivered beat is never zero
  a_rep_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_rep_r != '0)
    else $error("zero repeat count");

endmodule

### hw/rtl/tga_rle_pixel_decoder.sv
// TGA run-length pixel decoder, top level: APB register block, parser front,
// item queue and accounting back end. Depends on trd_pkg, trd_stream_if.
// Throughput: one stream byte per cycle while the queue is not full; one pixel result per cycle at most.
// Path: the edge that takes a pixel's last byte writes its item into the queue,
// and the output register loads it from the queue head once the output can take it.
// Reset (rst_n low, synchronous): header expected, queue and output empty,
// bytes_per_pixel = 4, pixel_total = 65536.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder #(
  parameter int MAX_BYTES_PER_PIXEL = trd_pkg::MAX_BYTES_PER_PIXEL_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  trd_byte_if.sink                     in_ch,
  trd_pixel_if.source                  out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [trd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [trd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [trd_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import trd_pkg::*;

  logic [BPP_W-1:0]   bpp_r;
  logic [TOTAL_W-1:0] total_r;
  logic               cfg_wr;
  logic               reload;
  logic [TOTAL_W-1:0] reload_total;

  logic       q_push, q_full, q_pop, q_valid;
  trd_item_t  q_item, q_head;

  // Register writes complete in the access phase
  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reload       = cfg_wr && (cfg_paddr[2] == REG_TOTAL);
  assign reload_total = eff_total(cfg_pwdata[TOTAL_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= BPP_RST;
      total_r <= TOTAL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_BPP:   bpp_r   <= cfg_pwdata[BPP_W-1:0];
        REG_TOTAL: total_r <= cfg_pwdata[TOTAL_W-1:0];
        default:   ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_paddr[2])
      REG_BPP:   cfg_prdata = {{(CFG_DW-BPP_W){1'b0}}, bpp_r};
      REG_TOTAL: cfg_prdata = {{(CFG_DW-TOTAL_W){1'b0}}, total_r};
      default:   cfg_prdata = '0;
    endcase
  end

  trd_front #(
    .MAX_BPP (MAX_BYTES_PER_PIXEL)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .bpp_cfg (bpp_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  trd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  trd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .reload       (reload),
    .reload_total (reload_total),
    .total_eff    (eff_total(total_r)),
    .out_ch       (out_ch)
  );

endmodule

### bench/tb.sv
// Self-checking bench for tga_rle_pixel_decoder: drives a TGA packet byte stream,
// predicts every pixel beat and compares it field by field on the result channel.
// Depends on trd_pkg, trd_stream_if and the decoder RTL.
`timescale 1ns / 1ps

module tb;
  import trd_pkg::*;

  localparam int unsigned MAX_BPP        = MAX_BYTES_PER_PIXEL_DEF;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RECV_STALL     = 160;
  localparam int unsigned PHASE_BYTES    = 240;
  localparam int unsigned SETTINGS_CNT   = 8;

  localparam logic [CFG_AW-1:0] BPP_ADDR   = {REG_BPP, 2'b00};
  localparam logic [CFG_AW-1:0] TOTAL_ADDR = {REG_TOTAL, 2'b00};

  // Fixed settings for the first random phases; later ones are drawn at random
  localparam int unsigned SET_BPP [6]   = '{1, 2, 3, 4, 2, 3};
  localparam int unsigned SET_TOTAL [6] = '{1, 5, 37, 200, 16777216, 33554431};

  // Directed streams: extreme runs and raw pixels, a pixel left half done,
  // a clipped run, a clipped raw packet whose tail is skipped
  localparam logic [7:0] OPEN_SEQ [13] = '{8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA,
                                           8'h00, 8'h12, 8'h34, 8'h56, 8'h78,
                                           8'h80, 8'h11, 8'h22};
  localparam logic [7:0] RUN_CLIP_SEQ [5] = '{8'h85, 8'hC3, 8'h3C, 8'h0F, 8'hF0};
  localparam logic [7:0] RAW_CLIP_SEQ [7] = '{8'h03, 8'hA5, 8'h5A, 8'hE7, 8'h7E,
                                              8'h84, 8'h99};

  typedef enum logic [1:0] {DEC_HEADER, DEC_PIXEL, DEC_SKIP} dec_phase_e;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [CNT_W-1:0] reps;
    logic             last;
    logic             ovr;
  } pixel_result_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  trd_byte_if  in_ch ();
  trd_pixel_if out_ch ();

  tga_rle_pixel_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Predictor copy of the registers and decode state
  logic [BPP_W-1:0]   bpp_reg   = BPP_RST;
  logic [TOTAL_W-1:0] total_reg = TOTAL_RST;
  dec_phase_e   dec_phase = DEC_HEADER;
  logic         run_pkt   = 1'b0;
  int unsigned  byte_pos  = 0;
  logic [31:0]  gather    = '0;
  int unsigned  pkt_left  = 0;
  int unsigned  img_left  = TOTAL_RST;

  pixel_result_t pixels_due [$];
  logic [7:0]    stream_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_asks    = 0;
  int unsigned stall_grants  = 0;
  int unsigned stall_left    = 0;
  int unsigned bytes_loaded  = 0;
  int unsigned bytes_taken   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches    = 0;
  int unsigned pixels_checked = 0;
  int unsigned images_closed = 0;
  int unsigned clipped       = 0;
  int unsigned reg_writes    = 0;

  function automatic int unsigned pixel_bytes();
    if (bpp_reg == '0) return 1;
    if (bpp_reg > MAX_BPP) return MAX_BPP;
    return bpp_reg;
  endfunction

  function automatic int unsigned image_pixels();
    return (total_reg == '0) ? 1 : total_reg;
  endfunction

  // Advance the decode state by one stream byte; queue the pixel it completes
  function automatic void decode_byte(input logic [7:0] b);
    int unsigned   bpp;
    int unsigned   reps;
    pixel_result_t r;
    bpp = pixel_bytes();
    // Drop bytes of raw pixels that fell past the image end
    if (dec_phase == DEC_SKIP) begin
      if (byte_pos + 1 >= bpp) begin
        byte_pos = 0;
        if (pkt_left > 0) pkt_left--;
        if (pkt_left == 0) dec_phase = DEC_HEADER;
      end else begin
        byte_pos++;
      end
      return;
    end
    // Open a packet
    if (dec_phase != DEC_PIXEL) begin
      run_pkt   = b[HDR_RUN_BIT];
      pkt_left  = 32'(b[6:0] & HDR_LEN_MASK) + 1;
      byte_pos  = 0;
      gather    = '0;
      dec_phase = DEC_PIXEL;
      return;
    end
    // Collect pixel bytes, first byte lowest
    gather |= 32'(b) << (8 * (byte_pos & 3));
    if (byte_pos + 1 < bpp) begin
      byte_pos++;
      return;
    end
    r.value  = gather;
    r.last   = 1'b0;
    r.ovr    = 1'b0;
    gather   = '0;
    byte_pos = 0;
    if (run_pkt) begin
      reps = pkt_left;
      if (reps > img_left) begin
        reps  = img_left;
        r.ovr = 1'b1;
      end
      img_left -= reps;
      pkt_left  = 0;
      dec_phase = DEC_HEADER;
    end else begin
      reps = 1;
      img_left--;
      pkt_left--;
      if (img_left == 0 && pkt_left > 0) begin
        r.ovr     = 1'b1;
        dec_phase = DEC_SKIP;
      end else if (pkt_left == 0) begin
        dec_phase = DEC_HEADER;
      end
    end
    if (img_left == 0) begin
      r.last   = 1'b1;
      img_left = image_pixels();
    end
    r.reps = 8'(reps);
    pixels_due.push_back(r);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    stream_q.push_back(b);
    bytes_loaded++;
  endtask

  // Build random packets for the current pixel size, cut off at the budget
  task automatic load_packets(input int unsigned budget);
    int unsigned n;
    int unsigned len;
    int unsigned npix;
    int unsigned pick;
    int unsigned bpp;
    bit          run;
    n = 0;
    bpp = pixel_bytes();
    while (n < budget) begin
      run  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 75) len = $urandom_range(0, 7);
      else if (pick < 95) len = $urandom_range(8, 31);
      else len = $urandom_range(32, 127);
      push_byte({run, 7'(len)});
      n++;
      npix = run ? 1 : len + 1;
      // Occasionally break a packet short so the next header lands mid-pixel
      if ($urandom_range(0, 19) == 0) npix = $urandom_range(0, npix);
      for (int unsigned i = 0; i < npix * bpp && n < budget; i++) begin
        pick = $urandom_range(0, 9);
        push_byte(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom()));
        n++;
      end
    end
  endtask

  // Wait until every byte is taken and every pixel beat is out, then settle
  task automatic drain_stream();
    while (bytes_taken != bytes_loaded) @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= (idx == REG_BPP) ? BPP_ADDR : TOTAL_ADDR;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_BPP) begin
      bpp_reg = data[BPP_W-1:0];
    end else begin
      total_reg = data[TOTAL_W-1:0];
      img_left  = image_pixels();
    end
    reg_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: offer queued bytes, hold a beat until taken, predict on accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.in_byte);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= stream_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each pixel beat against the oldest prediction, drive ready
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_due.size() == 0) begin
          $error("pixel beat with none predicted: value %h count %0d",
                 out_ch.pixel_value, out_ch.repeat_count);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          if (out_ch.pixel_value !== want.value) begin
            $error("pixel_value expected %h got %h", want.value, out_ch.pixel_value);
            mismatches++;
          end
          if (out_ch.repeat_count !== want.reps) begin
            $error("repeat_count expected %0d got %0d", want.reps, out_ch.repeat_count);
            mismatches++;
          end
          if (out_ch.last_of_image !== want.last) begin
            $error("last_of_image expected %b got %b", want.last, out_ch.last_of_image);
            mismatches++;
          end
          if (out_ch.overrun !== want.ovr) begin
            $error("overrun expected %b got %b", want.ovr, out_ch.overrun);
            mismatches++;
          end
          pixels_checked++;
          if (want.last) images_closed++;
          if (want.ovr) clipped++;
        end
      end
      // Hold ready low for a long stretch when asked, else idle at random
      if (stall_grants != stall_asks) begin
        stall_grants++;
        stall_left = RECV_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tga_rle_pixel_decoder verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned nb;
    int unsigned nt;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset settings
    send_idle_pct = 33;
    recv_idle_pct = 52;
    foreach (OPEN_SEQ[i]) push_byte(OPEN_SEQ[i]);
    drain_stream();
    // Shrink the pixel size under a half-gathered pixel; zero acts as one byte
    write_reg(REG_BPP, '0);
    push_byte(8'h33);
    drain_stream();
    // Oversized pixel size and zero image size, then a run past the image end
    write_reg(REG_BPP, 32'd7);
    write_reg(REG_TOTAL, '0);
    foreach (RUN_CLIP_SEQ[i]) push_byte(RUN_CLIP_SEQ[i]);
    drain_stream();
    // Raw packet crossing the image end, tail skipped, then a clipped run
    write_reg(REG_BPP, 32'd1);
    write_reg(REG_TOTAL, 32'd2);
    foreach (RAW_CLIP_SEQ[i]) push_byte(RAW_CLIP_SEQ[i]);
    drain_stream();

    // Random part: one register setting per phase
    for (int p = 0; p < SETTINGS_CNT; p++) begin
      if (p < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 52;
      end else if (p < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p < 6) begin
        nb = SET_BPP[p];
        nt = SET_TOTAL[p];
      end else begin
        nb = (p == 6) ? $urandom_range(1, MAX_BPP) : $urandom_range(0, 7);
        nt = $urandom_range(1, 64);
      end
      write_reg(REG_BPP, {29'($urandom()), 3'(nb)});
      write_reg(REG_TOTAL, {7'($urandom()), 25'(nt)});
      if (p == 1 || p == 6) stall_asks++;
      if (p == SETTINGS_CNT - 1) begin
        // Pause the sender halfway until every pixel beat is out
        load_packets(PHASE_BYTES / 2);
        drain_stream();
        load_packets(PHASE_BYTES / 2);
      end else begin
        load_packets(PHASE_BYTES);
      end
      drain_stream();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run: %0d stream bytes under %0d register writes, %0d pixel beats checked",
             bytes_taken, reg_writes, pixels_checked);
    $display("     %0d beats closed an image, %0d were clipped at the image end",
             images_closed, clipped);
    if (mismatches == 0) begin
      $display("tga_rle_pixel_decoder verification clean");
    end else begin
      $display("tga_rle_pixel_decoder verification failed");
    end
    $finish;
  end

endmodule
